// File: rtl/fsbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FNV-1a string bin classifier package
// Shared widths, hash constants, interface structs and the back-end states.
// ---------------------------------------------------------------------------
package fsbc_pkg;

   localparam int HashW = 32;
   localparam int ByteW = 8;
   localparam int BinW  = 16;
   localparam int CntW  = $clog2(HashW);

   localparam logic [HashW-1:0] FnvPrime  = 32'd16777619;
   localparam logic [HashW-1:0] FnvBasis  = 32'd2166136261;
   localparam logic [HashW-1:0] FullRange = 32'hFFFF_FFFF;

   typedef struct packed {
      logic             valid;
      logic [HashW-1:0] hash;
   } hash_push_type;

   typedef struct packed {
      logic             start;
      logic [HashW-1:0] dividend;
      logic [HashW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [HashW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_W,
      BK_DIV_Q,
      BK_HOLD
   } back_state_type;

endpackage : fsbc_pkg
`default_nettype wire

// File: rtl/fnv1a_string_bin_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FNV-1a string bin classifier
// Hashes byte strings with 32-bit FNV-1a and maps each hash to a bin.
// ---------------------------------------------------------------------------
// Bytes enter one per cycle on the req channel while req_stall is low and
// update the running hash in that cycle; a zero byte ends the string and
// queues its hash, then the hash restarts at the offset basis. The back end
// turns each queued hash into a bin with one shared bit-serial divider that
// runs two 32-step divisions, and gives one result transaction per string.
// Up to QUEUE_DEPTH finished strings wait in the queue; req_stall rises only
// while that queue is full. Write bin_count through csr_ only while no
// string end is pending; zero is treated as one bin.
// ---------------------------------------------------------------------------
module fnv1a_string_bin_classifier_unit
   import fsbc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ByteW-1:0] req_byte_value,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [BinW-1:0]       rsp_bin_index,
   input  wire logic             csr_wr_en,
   input  wire logic [BinW-1:0]  csr_wr_data
);

   logic [BinW-1:0]  bin_count_ff;
   hash_push_type    push;
   logic             queue_full;
   logic             queue_empty;
   logic [HashW-1:0] queue_head;
   logic             pop;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BinW'(1);
      end else if (csr_wr_en) begin
         bin_count_ff <= csr_wr_data;
      end
   end

   fsbc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_byte_value (req_byte_value),
      .queue_full     (queue_full),
      .req_stall      (req_stall),
      .push           (push)
   );

   fsbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (queue_head)
   );

   fsbc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fsbc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .queue_head    (queue_head),
      .bin_count     (bin_count_ff),
      .div_rsp       (div_rsp),
      .rsp_stall     (rsp_stall),
      .pop           (pop),
      .div_req       (div_req),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index)
   );

`ifndef SYNTHESIS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_full)
      else $error("Hash pushed into a full queue.");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("Hash popped from an empty queue.");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_bin_index < bin_count_ff) ||
                     ((bin_count_ff == '0) && (rsp_bin_index == '0))))
      else $error("Bin index outside the configured bin count.");
`endif

endmodule : fnv1a_string_bin_classifier_unit
`default_nettype wire

// File: rtl/fsbc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FNV-1a front end
// Accepts string bytes, keeps the running hash and queues finished hashes.
// ---------------------------------------------------------------------------
module fsbc_front
   import fsbc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [ByteW-1:0] req_byte_value,
   input  wire logic             queue_full,
   output logic                  req_stall,
   output hash_push_type         push
);

   logic [HashW-1:0] hash_ff;
   logic [HashW-1:0] hash_in;
   logic [HashW-1:0] mixed;
   logic             accept;
   logic             terminator;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign terminator = (req_byte_value == '0);
   assign mixed      = hash_ff ^ {{(HashW-ByteW){1'b0}}, req_byte_value};

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         if (terminator) begin
            hash_in = FnvBasis;
         end else begin
            hash_in = HashW'(mixed * FnvPrime);
         end
      end
   end

   assign push.valid = accept && terminator;
   assign push.hash  = hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FnvBasis;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule : fsbc_front
`default_nettype wire

// File: rtl/fsbc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hash queue
// Small FIFO of finished string hashes between the front and back ends.
// ---------------------------------------------------------------------------
module fsbc_queue
   import fsbc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire hash_push_type    push,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output logic [HashW-1:0]      head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntQW = $clog2(DEPTH + 1);

   logic [HashW-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntQW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] r;
      r = (p == PtrW'(DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
      return r;
   endfunction

   assign full  = (count_ff == CntQW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = CntQW'(count_ff + 1'b1);
      end else if (pop && !push.valid) begin
         count_in = CntQW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : fsbc_queue
`default_nettype wire

// File: rtl/fsbc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fsbc_divider
   import fsbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [HashW-1:0] rem_ff, rem_in;
   logic [HashW-1:0] quo_ff, quo_in;
   logic [HashW-1:0] divisor_ff, divisor_in;
   logic [HashW:0]   shifted;
   logic [HashW:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[HashW-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[HashW-1:0] : shifted[HashW-1:0];
         quo_in   = {quo_ff[HashW-2:0], fits};
         count_in = CntW'(count_ff + 1'b1);
         if (count_ff == CntW'(HashW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

endmodule : fsbc_divider
`default_nettype wire

// File: rtl/fsbc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bin back end
// Takes queued hashes, derives the bin with the shared divider and holds the
// result transaction until the consumer takes it.
// ---------------------------------------------------------------------------
module fsbc_back
   import fsbc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             queue_empty,
   input  wire logic [HashW-1:0] queue_head,
   input  wire logic [BinW-1:0]  bin_count,
   input  wire div_rsp_type      div_rsp,
   input  wire logic             rsp_stall,
   output logic                  pop,
   output div_req_type           div_req,
   output logic                  rsp_valid,
   output logic [BinW-1:0]       rsp_bin_index
);

   back_state_type   state_ff, state_in;
   logic [HashW-1:0] hash_ff;
   logic [BinW-1:0]  count_ff;
   logic [BinW-1:0]  res_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BinW-1:0]  rsp_bin_ff;
   logic [BinW-1:0]  bins_eff;
   logic             slot_free;
   logic             load_res;
   logic             load_rsp;

   assign bins_eff  = (bin_count == '0) ? BinW'(1) : bin_count;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!queue_empty) state_in = BK_DIV_W;
         BK_DIV_W: if (div_rsp.done) state_in = BK_DIV_Q;
         BK_DIV_Q: if (div_rsp.done) state_in = BK_HOLD;
         BK_HOLD:  if (slot_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop              = 1'b0;
      load_res         = 1'b0;
      load_rsp         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = hash_ff;
      div_req.divisor  = div_rsp.quotient;
      unique case (state_ff)
         BK_IDLE: begin
            pop              = !queue_empty;
            div_req.start    = !queue_empty;
            div_req.dividend = FullRange;
            div_req.divisor  = {{(HashW-BinW){1'b0}}, bins_eff};
         end
         BK_DIV_W: begin
            div_req.start = div_rsp.done;
         end
         BK_DIV_Q: begin
            load_res = div_rsp.done;
         end
         BK_HOLD: begin
            load_rsp = slot_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hash_ff  <= queue_head;
         count_ff <= bins_eff;
      end
      if (load_res) begin
         // A quotient equal to the bin count folds back into bin zero.
         res_ff <= (div_rsp.quotient == {{(HashW-BinW){1'b0}}, count_ff}) ?
                   '0 : div_rsp.quotient[BinW-1:0];
      end
      if (load_rsp) begin
         rsp_bin_ff <= res_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;

endmodule : fsbc_back
`default_nettype wire
